// File: rtl/sba_pkg.sv
// shared types, constants and helpers for the sector bitmap allocator
// no dependencies; imported by the scan unit and the top level
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

    localparam int MAP_BYTES_DEF = 8192;
    localparam int MAX_BLOCK_DEF = 16;
    localparam logic [15:0] HIGHEST_RESET = 16'd720;

    // operation codes carried in tuser
    typedef enum logic [2:0] {
        FN_LOAD  = 3'd0,
        FN_READ  = 3'd1,
        FN_MARK  = 3'd2,
        FN_TEST  = 3'd3,
        FN_FIND  = 3'd4,
        FN_BLOCK = 3'd5,
        FN_COUNT = 3'd6
    } func_t;

    // one map byte handed to the scan unit
    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  mask;    // same bit order as data
        logic [4:0]  run;     // free run carried in from the previous byte
        logic [4:0]  need;    // run length wanted, at least 1
        logic [15:0] base;    // sector number of the msb of data
    } scan_req_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] hit_sector;  // start of the run that completed
        logic [4:0]  run;
        logic [3:0]  free_bits;
    } scan_rsp_t;

    // msb of a map byte stands for the lowest sector
    function automatic logic [7:0] bit_of(input logic [2:0] k);
        return 8'(8'h80 >> k);
    endfunction

endpackage

`default_nettype wire

// File: rtl/sba_map_ram.sv
// free-space map storage: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sba_map_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/sba_scan_unit.sv
// shared byte scan unit: free run tracking, first hit and popcount over one map byte
// depends on sba_pkg
`timescale 1ns / 1ps
`default_nettype none

module sba_scan_unit (
    input  wire sba_pkg::scan_req_t req,
    output      sba_pkg::scan_rsp_t rsp
);

    import sba_pkg::*;

    logic [7:0] free_v;
    logic [4:0] run;
    logic       hit;
    logic [2:0] pos;
    logic [3:0] cnt;

    assign free_v = req.data & req.mask;

    // walk the byte from its lowest sector (msb) up
    always_comb
    begin
        run = req.run;
        hit = 1'b0;
        pos = '0;
        cnt = '0;
        for (int k = 0; k < 8; k++)
        begin
            cnt = cnt + 4'(free_v[7-k]);
            if (!hit)
            begin
                run = free_v[7-k] ? 5'(run + 5'd1) : 5'd0;
                if (run >= req.need)
                begin
                    hit = 1'b1;
                    pos = 3'(k);
                end
            end
        end
    end

    assign rsp.hit        = hit;
    assign rsp.hit_sector = 16'(req.base + 16'(pos) + 16'd1 - 16'(req.need));
    assign rsp.run        = run;
    assign rsp.free_bits  = cnt;

endmodule

`default_nettype wire

// File: rtl/sector_bitmap_allocator.sv
// sector free-space bitmap allocator, top level: sequencer, config register, output stage
// depends on sba_pkg, sba_map_ram and sba_scan_unit
// flow: load goes to the response state, read/mark/test through the memory state first;
//   searches and the count scan to the end byte, searches stopping at a hit, one map byte
//   per cycle through the single ram read port and the shared scan unit
// one item at a time; a new word is taken as soon as the sequencer is idle, even while
//   the previous result still waits in the output register
// reset: sequencer idle, output empty, highest_sector = 720; map contents undefined until loaded
`timescale 1ns / 1ps
`default_nettype none

module sector_bitmap_allocator #(
    parameter int MAP_BYTES = sba_pkg::MAP_BYTES_DEF,
    parameter int MAX_BLOCK = sba_pkg::MAX_BLOCK_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // byte_index[12:0], map_byte[20:13], sector[36:21], mark_used[37], block_len[42:38]
    input  wire logic [47:0] s_axis_tdata,
    // func[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    // result stream
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // found[0], found_sector[16:1], byte_out[24:17], sector_used[25], free_count[42:26]
    output      logic [47:0] m_axis_tdata,
    // highest_sector register
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    import sba_pkg::*;

    localparam int AW = $clog2(MAP_BYTES);
    localparam logic [13:0]   MAP_LIMIT = 14'(MAP_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MEM,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t       state_reg;
    func_t        op_reg;
    logic [15:0]  highest_reg;
    logic         oor_reg;       // map address beyond the store
    logic [AW-1:0] addr_reg;
    logic [2:0]   bit_reg;
    logic         mark_used_reg;
    logic [4:0]   need_reg;
    logic [4:0]   run_reg;
    logic [AW-1:0] issue_reg;    // next byte to read during a scan
    logic         issuing_reg;
    logic         pend_valid_reg;  // rd_data holds byte pend_idx_reg
    logic [AW-1:0] pend_idx_reg;
    logic [AW-1:0] end_reg;      // last byte of the scan

    // result being built
    logic         res_found_reg;
    logic [15:0]  res_sector_reg;
    logic [7:0]   res_byte_reg;
    logic         res_used_reg;
    logic [16:0]  res_count_reg;

    logic         m_valid_reg;
    logic [47:0]  m_data_reg;

    // input unpack
    func_t        in_func;
    logic [12:0]  in_bidx;
    logic [7:0]   in_map_byte;
    logic [15:0]  in_sector;
    logic         in_mark_used;
    logic [4:0]   in_block_len;
    logic [4:0]   in_need;
    logic [12:0]  in_addr13;
    logic         in_range;
    logic         accept;
    logic [12:0]  end13;

    logic         wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]   wr_data;
    logic         rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]   rd_data;
    logic [7:0]   mem_byte;
    logic [7:0]   mark_byte;

    scan_req_t    scan_req;
    scan_rsp_t    scan_rsp;
    logic         is_search;
    logic         scan_last;

    assign in_func      = func_t'(s_axis_tuser);
    assign in_bidx      = s_axis_tdata[12:0];
    assign in_map_byte  = s_axis_tdata[20:13];
    assign in_sector    = s_axis_tdata[36:21];
    assign in_mark_used = s_axis_tdata[37];
    assign in_block_len = s_axis_tdata[42:38];

    // block length 0 acts as 1; find free is a block search of length 1
    assign in_need = (in_func == FN_FIND || in_block_len == 5'd0) ? 5'd1 : in_block_len;

    assign in_addr13 = (in_func == FN_LOAD || in_func == FN_READ) ? in_bidx : in_sector[15:3];
    assign in_range  = {1'b0, in_addr13} < MAP_LIMIT;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // scan ends at the byte holding highest_sector, clipped to the store
    assign end13 = highest_reg[15:3];

    // valid sectors of one byte: up to highest_sector, skipping sector 0 on searches
    function automatic logic [7:0] byte_mask(input logic [12:0] b, input logic [15:0] hi,
                                             input logic skip0);
        logic [7:0] m;
        if (b < hi[15:3])
            m = 8'hFF;
        else if (b == hi[15:3])
            m = 8'(8'hFF << (3'd7 - hi[2:0]));
        else
            m = 8'h00;
        if (skip0 && b == 13'd0)
            m[7] = 1'b0;
        return m;
    endfunction

    assign mem_byte  = oor_reg ? 8'h00 : rd_data;
    assign mark_byte = mark_used_reg ? (rd_data & ~bit_of(bit_reg)) : (rd_data | bit_of(bit_reg));

    // ram port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = mark_byte;
        rd_en   = 1'b0;
        rd_addr = issue_reg;
        if (state_reg == ST_IDLE)
        begin
            wr_addr = in_addr13[AW-1:0];
            wr_data = in_map_byte;
            rd_addr = in_addr13[AW-1:0];
            wr_en   = accept && in_range && (in_func == FN_LOAD);
            rd_en   = accept && in_range &&
                      (in_func == FN_READ || in_func == FN_MARK || in_func == FN_TEST);
        end
        else if (state_reg == ST_MEM)
        begin
            wr_en = (op_reg == FN_MARK) && !oor_reg;
        end
        else if (state_reg == ST_SCAN)
        begin
            rd_en = issuing_reg;
        end
    end

    sba_map_ram #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared scan unit works on the byte returned by the previous read
    assign is_search     = (op_reg != FN_COUNT);
    assign scan_req.data = rd_data;
    assign scan_req.mask = byte_mask(13'(pend_idx_reg), highest_reg, is_search);
    assign scan_req.run  = run_reg;
    assign scan_req.need = need_reg;
    assign scan_req.base = 16'({pend_idx_reg, 3'b000});

    sba_scan_unit u_scan (
        .req (scan_req),
        .rsp (scan_rsp)
    );

    assign scan_last = (pend_idx_reg == end_reg);

    // sequencer, config register and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            highest_reg    <= HIGHEST_RESET;
            issuing_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                highest_reg <= cfg_wr_data;
            end

            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg         <= in_func;
                        oor_reg        <= !in_range;
                        addr_reg       <= in_addr13[AW-1:0];
                        bit_reg        <= in_sector[2:0];
                        mark_used_reg  <= in_mark_used;
                        need_reg       <= in_need;
                        run_reg        <= '0;
                        issue_reg      <= '0;
                        pend_valid_reg <= 1'b0;
                        end_reg        <= ({1'b0, end13} >= MAP_LIMIT) ? LAST_ADDR
                                                                       : end13[AW-1:0];
                        res_found_reg  <= 1'b0;
                        res_sector_reg <= '0;
                        res_byte_reg   <= '0;
                        res_used_reg   <= 1'b0;
                        res_count_reg  <= '0;
                        priority case (in_func)
                            FN_READ, FN_MARK, FN_TEST:
                            begin
                                state_reg <= ST_MEM;
                            end
                            FN_FIND, FN_COUNT:
                            begin
                                issuing_reg <= 1'b1;
                                state_reg   <= ST_SCAN;
                            end
                            FN_BLOCK:
                            begin
                                if (32'(in_need) > MAX_BLOCK)
                                begin
                                    state_reg <= ST_RESP;
                                end
                                else
                                begin
                                    issuing_reg <= 1'b1;
                                    state_reg   <= ST_SCAN;
                                end
                            end
                            default:
                            begin
                                // load, and the unused code
                                state_reg <= ST_RESP;
                            end
                        endcase
                    end
                end

                ST_MEM:
                begin
                    if (op_reg == FN_READ)
                    begin
                        res_byte_reg <= mem_byte;
                    end
                    if (op_reg == FN_TEST)
                    begin
                        res_used_reg <= ((mem_byte & bit_of(bit_reg)) == 8'h00);
                    end
                    state_reg <= ST_RESP;
                end

                ST_SCAN:
                begin
                    // read side: one byte per cycle up to end_reg
                    if (issuing_reg)
                    begin
                        pend_valid_reg <= 1'b1;
                        pend_idx_reg   <= issue_reg;
                        if (issue_reg == end_reg)
                        begin
                            issuing_reg <= 1'b0;
                        end
                        else
                        begin
                            issue_reg <= issue_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pend_valid_reg <= 1'b0;
                    end

                    // evaluate side
                    if (pend_valid_reg)
                    begin
                        run_reg       <= scan_rsp.run;
                        res_count_reg <= res_count_reg + 17'(scan_rsp.free_bits);
                        if (is_search && scan_rsp.hit)
                        begin
                            res_found_reg  <= 1'b1;
                            res_sector_reg <= scan_rsp.hit_sector;
                        end
                        if ((is_search && scan_rsp.hit) || scan_last)
                        begin
                            issuing_reg    <= 1'b0;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= ST_RESP;
                        end
                    end
                end

                ST_RESP:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {5'b00000,
                                        is_search ? 17'd0 : res_count_reg,
                                        res_used_reg,
                                        res_byte_reg,
                                        res_sector_reg,
                                        res_found_reg};
                        state_reg   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // scan never reads past the last byte of its range
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issuing_reg |-> (issue_reg <= end_reg))
        else $error("scan read beyond end byte");

    // map store is never written and read in one cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("map written and read together");

    // returned byte data is only tracked while scanning
    a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_SCAN))
        else $error("pending byte outside scan");

    // a new result only comes out of the response state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside response state");

    // the free count never exceeds the sector space
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP) |-> (res_count_reg <= 17'd65536))
        else $error("free count out of range");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for sector_bitmap_allocator: fills the whole map, walks a table
// of directed words, then random words under several highest_sector settings
// depends on sba_pkg and the allocator rtl; results checked against an in-bench predictor
`timescale 1ns / 1ps

module tb_top;

    import sba_pkg::*;

    // tuser code with no operation behind it
    localparam logic [2:0] FN_UNUSED = 3'd7;
    localparam int NUM_DIRECTED = 24;
    localparam int NUM_PHASES = 6;
    localparam int MAX_REPORTS = 10;
    localparam int LONG_HOLD_CYCLES = 400;

    // input word, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [4:0]  block_len;
        logic        mark_used;
        logic [15:0] sector;
        logic [7:0]  map_byte;
        logic [12:0] byte_index;
    } alloc_cmd_t;

    // result word, same packing
    typedef struct packed {
        logic [4:0]  pad;
        logic [16:0] free_count;
        logic        sector_used;
        logic [7:0]  byte_out;
        logic [15:0] found_sector;
        logic        found;
    } alloc_rsp_t;

    typedef struct packed {
        logic [2:0] op;
        alloc_rsp_t rsp;
    } awaited_t;

    // one directed word; pinned rows carry their expected byte_out and sector_used,
    // every other output field of a pinned row is zero
    typedef struct packed {
        logic [2:0]  op;
        logic [12:0] byte_index;
        logic [7:0]  map_byte;
        logic [15:0] sector;
        logic        mark_used;
        logic [4:0]  block_len;
        logic        pinned;
        logic [7:0]  exp_byte;
        logic        exp_used;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    // predictor state: a shadow of the map and of the register
    logic [7:0]  shadow_map [0:MAP_BYTES_DEF-1];
    logic [15:0] shadow_highest;

    awaited_t awaited_results [$];

    // shared between the driving processes
    bit no_idle;
    int long_hold;
    int mismatches;
    int results_checked;
    int loads_sent;
    int scans_sent;

    // directed table, run right after the map fill with highest_sector at its reset value
    stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        // only sector 0 free in byte 0, then read and test it back
        '{FN_LOAD,   13'd0,    8'h80, 16'd0,     1'b0, 5'd1,  1'b1, 8'h00, 1'b0},
        '{FN_READ,   13'd0,    8'h00, 16'd0,     1'b0, 5'd1,  1'b1, 8'h80, 1'b0},
        '{FN_TEST,   13'd0,    8'h00, 16'd0,     1'b0, 5'd1,  1'b1, 8'h00, 1'b0},
        '{FN_TEST,   13'd0,    8'h00, 16'd1,     1'b0, 5'd1,  1'b1, 8'h00, 1'b1},
        // top of the map and the upper half
        '{FN_LOAD,   13'd8191, 8'hFF, 16'd0,     1'b0, 5'd1,  1'b1, 8'h00, 1'b0},
        '{FN_READ,   13'd8191, 8'h00, 16'd0,     1'b0, 5'd1,  1'b1, 8'hFF, 1'b0},
        '{FN_LOAD,   13'd4096, 8'h01, 16'd0,     1'b0, 5'd1,  1'b1, 8'h00, 1'b0},
        '{FN_READ,   13'd4096, 8'h00, 16'd0,     1'b0, 5'd1,  1'b1, 8'h01, 1'b0},
        '{FN_TEST,   13'd0,    8'h00, 16'd65535, 1'b0, 5'd1,  1'b1, 8'h00, 1'b0},
        '{FN_MARK,   13'd0,    8'h00, 16'd65535, 1'b1, 5'd1,  1'b1, 8'h00, 1'b0},
        '{FN_TEST,   13'd0,    8'h00, 16'd65535, 1'b0, 5'd1,  1'b1, 8'h00, 1'b1},
        '{FN_MARK,   13'd0,    8'h00, 16'd32768, 1'b0, 5'd1,  1'b1, 8'h00, 1'b0},
        '{FN_READ,   13'd4096, 8'h00, 16'd0,     1'b0, 5'd1,  1'b1, 8'h81, 1'b0},
        '{FN_LOAD,   13'd1,    8'h00, 16'd0,     1'b0, 5'd1,  1'b1, 8'h00, 1'b0},
        // searches over the filled map, sector 0 free but outside the search range
        '{FN_FIND,   13'd0,    8'h00, 16'd0,     1'b0, 5'd1,  1'b0, 8'h00, 1'b0},
        '{FN_BLOCK,  13'd0,    8'h00, 16'd0,     1'b0, 5'd0,  1'b0, 8'h00, 1'b0},
        '{FN_BLOCK,  13'd0,    8'h00, 16'd0,     1'b0, 5'd1,  1'b0, 8'h00, 1'b0},
        '{FN_BLOCK,  13'd0,    8'h00, 16'd0,     1'b0, 5'd16, 1'b0, 8'h00, 1'b0},
        // run length past the limit never fits
        '{FN_BLOCK,  13'd0,    8'h00, 16'd0,     1'b0, 5'd17, 1'b1, 8'h00, 1'b0},
        '{FN_BLOCK,  13'd0,    8'h00, 16'd0,     1'b0, 5'd31, 1'b1, 8'h00, 1'b0},
        '{FN_COUNT,  13'd0,    8'h00, 16'd0,     1'b0, 5'd1,  1'b0, 8'h00, 1'b0},
        // unused code with every field at its top value
        '{FN_UNUSED, 13'd8191, 8'hFF, 16'd65535, 1'b1, 5'd31, 1'b1, 8'h00, 1'b0},
        '{FN_MARK,   13'd0,    8'h00, 16'd0,     1'b1, 5'd1,  1'b1, 8'h00, 1'b0},
        '{FN_TEST,   13'd0,    8'h00, 16'd0,     1'b0, 5'd1,  1'b1, 8'h00, 1'b1}
    };

    sector_bitmap_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #10 clk = ~clk;

    // msb of a map byte is the lowest sector, set means free
    function automatic logic sector_free(input logic [15:0] sec);
        return shadow_map[sec[15:3]][3'd7 - sec[2:0]];
    endfunction

    // expected result word for one accepted operation; updates the shadow map
    function automatic alloc_rsp_t bitmap_outcome(input logic [2:0] op, input alloc_cmd_t c);
        alloc_rsp_t r;
        logic [16:0] s;
        int run_len;
        int need;
        int free_total;
        r = '0;
        case (op)
            FN_LOAD: shadow_map[c.byte_index] = c.map_byte;
            FN_READ: r.byte_out = shadow_map[c.byte_index];
            FN_MARK: shadow_map[c.sector[15:3]][3'd7 - c.sector[2:0]] = ~c.mark_used;
            FN_TEST: r.sector_used = ~sector_free(c.sector);
            FN_FIND:
            begin
                // sector 0 is never handed out
                for (s = 17'd1; s <= shadow_highest; s++)
                begin
                    if (sector_free(s[15:0]))
                    begin
                        r.found = 1'b1;
                        r.found_sector = s[15:0];
                        break;
                    end
                end
            end
            FN_BLOCK:
            begin
                // zero length asks for a single sector
                need = (c.block_len == 5'd0) ? 1 : int'(c.block_len);
                if (need <= MAX_BLOCK_DEF)
                begin
                    run_len = 0;
                    for (s = 17'd1; s <= shadow_highest; s++)
                    begin
                        run_len = sector_free(s[15:0]) ? run_len + 1 : 0;
                        if (run_len >= need)
                        begin
                            r.found = 1'b1;
                            r.found_sector = 16'(int'(s) + 1 - need);
                            break;
                        end
                    end
                end
            end
            FN_COUNT:
            begin
                // the count includes sector 0
                free_total = 0;
                for (s = 17'd0; s <= shadow_highest; s++)
                    if (sector_free(s[15:0]))
                        free_total++;
                r.free_count = 17'(free_total);
            end
            default: ;
        endcase
        return r;
    endfunction

    // drive one word after a random gap, wait for the handshake, log its expected result
    task automatic send_word(input logic [2:0] op, input alloc_cmd_t c, input bit pinned,
                             input alloc_rsp_t pinned_rsp);
        int gap;
        awaited_t w;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        w.op  = op;
        w.rsp = bitmap_outcome(op, c);
        if (pinned)
            w.rsp = pinned_rsp;
        awaited_results.push_back(w);
        if (op == FN_LOAD)
            loads_sent++;
        if (op == FN_FIND || op == FN_BLOCK || op == FN_COUNT)
            scans_sent++;
    endtask

    function automatic void compare_field(input string field, input logic [2:0] op,
                                          input int unsigned expv, input int unsigned gotv);
        if (expv != gotv)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch op %0d %s: expected %0d got %0d", op, field, expv, gotv);
        end
    endfunction

    task automatic check_result(input alloc_rsp_t got);
        awaited_t w;
        results_checked++;
        if (awaited_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: result word with none awaited, data %h", got);
            return;
        end
        w = awaited_results.pop_front();
        compare_field("found", w.op, w.rsp.found, got.found);
        compare_field("found_sector", w.op, w.rsp.found_sector, got.found_sector);
        compare_field("byte_out", w.op, w.rsp.byte_out, got.byte_out);
        compare_field("sector_used", w.op, w.rsp.sector_used, got.sector_used);
        compare_field("free_count", w.op, w.rsp.free_count, got.free_count);
    endtask

    // result side: random stall before each word, one long hold-off on request
    initial
    begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (long_hold > 0)
            begin
                stall = long_hold;
                long_hold = 0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            check_result(m_axis_tdata);
        end
    end

    // stimulus: reset, full map fill, directed table, then random phases
    initial
    begin : stimulus
        int i;
        int p;
        int n;
        int r;
        int phase_len [NUM_PHASES];
        logic [15:0] phase_highest [NUM_PHASES];
        logic [2:0] op;
        alloc_cmd_t c;
        alloc_rsp_t pinned_rsp;
        stim_row_t row;

        // first phase keeps the reset value; the rest cover both extremes, the empty
        // range, a single sector, a byte boundary and a random middle value
        phase_len     = '{20, 15, 10, 10, 25, 15};
        phase_highest = '{HIGHEST_RESET, 16'd65535, 16'd0, 16'd1,
                          16'($urandom_range(2, 2047)), 16'd8};

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FN_LOAD;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        shadow_highest = HIGHEST_RESET;
        no_idle = 1'b0;
        long_hold = 0;
        mismatches = 0;
        results_checked = 0;
        loads_sent = 0;
        scans_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load every map byte so that no scan ever touches an unwritten byte;
        // mostly used sectors so searches have to walk a fair way
        no_idle = 1'b1;
        for (i = 0; i < MAP_BYTES_DEF; i++)
        begin
            c = '0;
            c.byte_index = 13'(i);
            r = $urandom_range(0, 99);
            c.map_byte = (r < 88) ? 8'h00 : (r < 94) ? 8'hFF : 8'($urandom);
            send_word(FN_LOAD, c, 1'b0, '0);
        end
        no_idle = 1'b0;

        for (i = 0; i < NUM_DIRECTED; i++)
        begin
            row = directed_rows[i];
            c = '0;
            c.byte_index = row.byte_index;
            c.map_byte   = row.map_byte;
            c.sector     = row.sector;
            c.mark_used  = row.mark_used;
            c.block_len  = row.block_len;
            pinned_rsp = '0;
            pinned_rsp.byte_out    = row.exp_byte;
            pinned_rsp.sector_used = row.exp_used;
            send_word(row.op, c, row.pinned, pinned_rsp);
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                // register changes only with the block idle and every result back
                s_axis_tvalid <= 1'b0;
                while (awaited_results.size() != 0)
                    @(posedge clk);
                repeat (4) @(posedge clk);
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= phase_highest[p];
                @(posedge clk);
                cfg_wr_en <= 1'b0;
                shadow_highest = phase_highest[p];
            end
            else
                long_hold = LONG_HOLD_CYCLES;  // result side stalls, input side backs up

            for (n = 0; n < phase_len[p]; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 14)
                    op = FN_LOAD;
                else if (r < 28)
                    op = FN_READ;
                else if (r < 48)
                    op = FN_MARK;
                else if (r < 62)
                    op = FN_TEST;
                else if (r < 74)
                    op = FN_FIND;
                else if (r < 88)
                    op = FN_BLOCK;
                else if (r < 97)
                    op = FN_COUNT;
                else
                    op = FN_UNUSED;

                // half the addresses land inside the searched range
                c = '0;
                c.byte_index = $urandom_range(0, 1) ?
                    13'($urandom_range(0, shadow_highest >> 3)) : 13'($urandom_range(0, 8191));
                c.sector = $urandom_range(0, 1) ?
                    16'($urandom_range(0, shadow_highest)) : 16'($urandom);
                r = $urandom_range(0, 9);
                c.map_byte = (r < 3) ? 8'h00 : (r < 5) ? 8'hFF : 8'($urandom);
                c.mark_used = 1'($urandom_range(0, 1));
                r = $urandom_range(0, 9);
                if (r < 8)
                    c.block_len = 5'($urandom_range(1, MAX_BLOCK_DEF));
                else if (r == 8)
                    c.block_len = 5'd0;
                else
                    c.block_len = 5'($urandom_range(MAX_BLOCK_DEF + 1, 31));
                send_word(op, c, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then leave room for any stray word
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("checked %0d result words: %0d map loads, %0d searches and counts",
                 results_checked, loads_sent, scans_sent);
        $display("highest_sector swept over %0d settings incl. 0, 1 and 65535, %0d mismatches",
                 NUM_PHASES, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // timeout covers the worst case, with every word a full-map scan, five times over
    initial
    begin : watchdog
        #100_000_000;
        $display("timeout with %0d results still awaited", awaited_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
